[rtl/core/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 11;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 112;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_FINISH
  } deq_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
    logic out_load;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_load;
  } deq_status_t;

endpackage

[rtl/core/deq_ram.sv]
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/deq_ctrl.sv]
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  deq_pkg::deq_status_t status,
  output deq_pkg::deq_cmd_t    cmd
);

  import deq_pkg::*;

  deq_state_t state;
  deq_state_t state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    accept       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        accept      = s_tvalid;
        cmd.capture = accept;
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.need_load ? ST_LOAD : ST_FINISH;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // result leaves and the next request may enter in the same cycle
        s_tready     = out_free;
        accept       = s_tvalid && out_free;
        cmd.capture  = accept;
        cmd.out_load = out_free;
        if (out_free) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/deq_datapath.sv]
`timescale 1ns / 1ps

module deq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  deq_pkg::deq_cmd_t             cmd,
  output deq_pkg::deq_status_t          status,
  input  logic [deq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [deq_pkg::DATA_W-1:0]    in_value,
  output logic [deq_pkg::OUT_W-1:0]     out_data
);

  import deq_pkg::*;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [ADDR_W-1:0] fp;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] front_word;
  logic [DATA_W-1:0] back_word;
  logic              ok_q;
  logic [DATA_W-1:0] popped_q;
  logic              load_front;

  logic [ADDR_W-1:0] fp_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              ok_next;
  logic [DATA_W-1:0] popped_next;
  logic              set_front;
  logic              set_back;
  logic              load_front_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic [ADDR_W-1:0] fp_dec;
  logic [ADDR_W-1:0] fp_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  back2_sum;
  logic [ADDR_W-1:0] tail_idx;
  logic [ADDR_W-1:0] back2_idx;
  logic              empty;
  logic              full;

  assign empty = (cnt == '0);
  assign full  = (cnt == CNT_W'(DEPTH));

  assign fp_dec    = (fp == '0) ? ADDR_W'(DEPTH - 1) : fp - 1'b1;
  assign fp_inc    = (fp == ADDR_W'(DEPTH - 1)) ? '0 : fp + 1'b1;
  assign tail_sum  = SUM_W'(fp) + SUM_W'(cnt);
  // only used when two or more words are stored
  assign back2_sum = SUM_W'(fp) + SUM_W'(cnt) - SUM_W'(2);
  assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : ADDR_W'(tail_sum);
  assign back2_idx = (back2_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back2_sum - SUM_W'(DEPTH))
                                                   : ADDR_W'(back2_sum);

  always_comb begin
    fp_next         = fp;
    cnt_next        = cnt;
    ok_next         = 1'b0;
    popped_next     = '0;
    set_front       = 1'b0;
    set_back        = 1'b0;
    load_front_next = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = tail_idx;
    rd_en           = 1'b0;
    rd_addr         = fp_inc;
    status.need_load = 1'b0;
    case (cmd_q)
      CMD_PUSH_FRONT: begin
        if (!full) begin
          fp_next   = fp_dec;
          cnt_next  = cnt + 1'b1;
          ok_next   = 1'b1;
          wr_en     = cmd.exec;
          wr_addr   = fp_dec;
          set_front = 1'b1;
          set_back  = empty;
        end
      end
      CMD_PUSH_BACK: begin
        if (!full) begin
          cnt_next  = cnt + 1'b1;
          ok_next   = 1'b1;
          wr_en     = cmd.exec;
          wr_addr   = tail_idx;
          set_back  = 1'b1;
          set_front = empty;
        end
      end
      CMD_POP_FRONT: begin
        if (!empty) begin
          fp_next         = fp_inc;
          cnt_next        = cnt - 1'b1;
          ok_next         = 1'b1;
          popped_next     = front_word;
          load_front_next = 1'b1;
          rd_addr         = fp_inc;
          status.need_load = (cnt != CNT_W'(1));
          rd_en           = cmd.exec && status.need_load;
        end
      end
      CMD_POP_BACK: begin
        if (!empty) begin
          cnt_next        = cnt - 1'b1;
          ok_next         = 1'b1;
          popped_next     = back_word;
          rd_addr         = back2_idx;
          status.need_load = (cnt != CNT_W'(1));
          rd_en           = cmd.exec && status.need_load;
        end
      end
      CMD_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fp  <= '0;
      cnt <= '0;
    end else if (cmd.exec) begin
      fp  <= fp_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= in_cmd;
      value_q <= in_value;
    end
    if (cmd.exec) begin
      ok_q       <= ok_next;
      popped_q   <= popped_next;
      load_front <= load_front_next;
      if (set_front) begin
        front_word <= value_q;
      end
      if (set_back) begin
        back_word <= value_q;
      end
    end
    if (cmd.load) begin
      if (load_front) begin
        front_word <= rd_data;
      end else begin
        back_word <= rd_data;
      end
    end
    if (cmd.out_load) begin
      out_data <= {2'b00,
                   empty ? '0 : back_word,
                   empty ? '0 : front_word,
                   full,
                   empty,
                   COUNT_W'(cnt),
                   popped_q,
                   ok_q};
    end
  end

endmodule

[rtl/core/double_ended_queue.sv]
`timescale 1ns / 1ps
// channel  direction  bus                     contents
// s        in         s_tdata[31:0]           value
//                     s_tuser[2:0]            cmd
// m        out        m_tdata[111:0]          ok, popped_value, count, is_empty,
//                                             is_full, front_value, back_value
//
// a push or query passes through the exec and finish states, a pop that leaves words behind
// also passes through the load state between them: the ram read of the new front or back word
// the next request is taken in the cycle the previous result is registered
// a stalled m side holds its result; one more request is taken and executed,
// then s_tready stays low until the held result leaves
// rst is synchronous; the word store needs no clearing pass

module double_ended_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [deq_pkg::IN_W-1:0]       s_tdata,   // value[31:0]
  input  logic [deq_pkg::CMD_W-1:0]      s_tuser,   // cmd[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // ok[0], popped_value[32:1], count[43:33], is_empty[44], is_full[45],
  // front_value[77:46], back_value[109:78], zero[111:110]
  output logic [deq_pkg::OUT_W-1:0]      m_tdata
);

  import deq_pkg::*;

  deq_cmd_t    cmd;
  deq_status_t status;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  deq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_cmd   (s_tuser),
    .in_value (s_tdata[DATA_W-1:0]),
    .out_data (m_tdata)
  );

endmodule

[rtl/core/deq_checker.sv]
`timescale 1ns / 1ps

module deq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [deq_pkg::OUT_W-1:0] m_tdata
);

  import deq_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // empty flag agrees with count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44] == (m_tdata[43:33] == '0)))
    else $error("empty flag disagrees with count");

  // never empty and full together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[44] && m_tdata[45]))
    else $error("empty and full both set");

  // a failed request pops nothing
  a_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == '0))
    else $error("failed request returned a word");

  // an empty queue shows zero front and back words
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[44] |-> (m_tdata[77:46] == '0) && (m_tdata[109:78] == '0))
    else $error("empty queue shows a word");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int MIX_ITEMS   = 200;

  // one result as it appears on m_tdata, msb first
  typedef struct packed {
    logic [1:0]         pad;
    logic [DATA_W-1:0]  back_word;
    logic [DATA_W-1:0]  front_word;
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  popped;
    logic               ok;
  } deque_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] words [DEPTH];
    int unsigned       head;
    int unsigned       level;
    deque_result_t     outstanding_results[$];
    int                errors;
    int                requests_seen;
    int                results_seen;
    int                refused_pushes;
    int                empty_pops;
    int                bad_commands;
    int unsigned       peak_level;

    function new();
      head = 0;
      level = 0;
      errors = 0;
      requests_seen = 0;
      results_seen = 0;
      refused_pushes = 0;
      empty_pops = 0;
      bad_commands = 0;
      peak_level = 0;
    endfunction

    function int pending();
      return outstanding_results.size();
    endfunction

    // deque update for one accepted request, queues the result it produces
    function void apply_command(logic [CMD_W-1:0] op, logic [DATA_W-1:0] value);
      deque_result_t r;
      r = '0;
      requests_seen++;
      case (op)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (level < DEPTH) begin
            if (op == CMD_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              words[head] = value;
            end else begin
              words[(head + level) % DEPTH] = value;
            end
            level++;
            r.ok = 1'b1;
          end else begin
            refused_pushes++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (level != 0) begin
            if (op == CMD_POP_FRONT) begin
              r.popped = words[head];
              head = (head + 1) % DEPTH;
            end else begin
              r.popped = words[(head + level - 1) % DEPTH];
            end
            level--;
            r.ok = 1'b1;
          end else begin
            empty_pops++;
          end
        end
        CMD_QUERY: r.ok = 1'b1;
        default: bad_commands++;
      endcase
      if (level > peak_level) peak_level = level;
      r.count = level[COUNT_W-1:0];
      r.empty = (level == 0);
      r.full  = (level == DEPTH);
      if (level != 0) begin
        r.front_word = words[head];
        r.back_word  = words[(head + level - 1) % DEPTH];
      end
      outstanding_results.insert(outstanding_results.size(), r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, want %h", results_seen, name, got, want));
    endtask

    task check_result(logic [OUT_W-1:0] bus);
      deque_result_t got;
      deque_result_t want;
      got = bus;
      results_seen++;
      if (outstanding_results.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = outstanding_results[0];
        outstanding_results.delete(0);
        compare_field("ok", got.ok, want.ok);
        compare_field("popped", got.popped, want.popped);
        compare_field("count", got.count, want.count);
        compare_field("empty", got.empty, want.empty);
        compare_field("full", got.full, want.full);
        compare_field("front", got.front_word, want.front_word);
        compare_field("back", got.back_word, want.back_word);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [CMD_W-1:0]    s_tuser = CMD_QUERY;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;

  deque_scoreboard sb = new();

  // stimulus side state
  int unsigned stim_level = 0;
  int          burst_left = 0;
  bit          sender_idles = 0;
  int          rx_mode = 0;
  bit          hold_request = 0;
  int          idle_cycles = 0;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.apply_command(s_tuser, s_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // receiver: stall pattern chosen per phase, plus one long hold on request
  initial begin : receiver
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 99) < 55);
          default: m_tready <= ((tick % 7) > 2);
        endcase
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int push_pct);
    int r;
    logic [CMD_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = CMD_QUERY + CMD_W'($urandom_range(1, 3));
    end else if (r < 10) begin
      op = CMD_QUERY;
    end else if ($urandom_range(0, 99) < push_pct) begin
      op = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      op = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end
    return op;
  endfunction

  task send_request(logic [CMD_W-1:0] op, logic [DATA_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: if (stim_level < DEPTH) stim_level++;
      CMD_POP_FRONT, CMD_POP_BACK: if (stim_level > 0) stim_level--;
      default: ;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender goes quiet until every outstanding result has been taken
  task wait_for_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    // let the monitor record the last accepted request first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int n;
    int push_pct;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty corner cases, extremes, both ends, wrap of the front index
    send_request(CMD_QUERY, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_POP_BACK, 32'hffff_ffff);
    send_request(CMD_QUERY + 3'd1, 32'hffff_ffff);
    send_request(CMD_QUERY + 3'd2, 32'h5555_5555);
    send_request(CMD_QUERY + 3'd3, 32'haaaa_aaaa);
    send_request(CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_request(CMD_QUERY, 32'h1234_5678);
    send_request(CMD_PUSH_FRONT, 32'h0);
    send_request(CMD_PUSH_BACK, 32'hffff_ffff);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_PUSH_BACK, 32'h0000_0001);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_PUSH_FRONT, 32'h0000_0002);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_POP_BACK, 32'h0);
    wait_for_results();

    // fill to full under a long receiver hold, then push on full
    rx_mode = 1;
    sender_idles = 1;
    hold_request = 1;
    while (stim_level < DEPTH)
      send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word());
    repeat (4)
      send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word());
    send_request(CMD_QUERY, rand_word());
    rx_mode = 2;
    wait_for_results();

    // random mix from near full in short phases with varying push bias
    n = 0;
    while (n < MIX_ITEMS) begin
      rx_mode = $urandom_range(0, 2);
      sender_idles = $urandom_range(0, 3) != 0;
      push_pct = $urandom_range(30, 75);
      repeat (100) begin
        send_request(pick_command(push_pct), rand_word());
        n++;
      end
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d requests and %0d results, peak occupancy %0d of %0d",
             sb.requests_seen, sb.results_seen, sb.peak_level, DEPTH);
    $display("refused pushes %0d, pops on empty %0d, unknown commands %0d",
             sb.refused_pushes, sb.empty_pops, sb.bad_commands);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
